>>> hdl/color_string_parser_core_defines.svh
// assertion macros for the color string parser
`ifndef COLOR_STRING_PARSER_CORE_DEFINES_SVH
`define COLOR_STRING_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CSP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csp assertion failed");
`define CSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csp assertion failed");
`else
`define CSP_ASSERT_SAME(lbl, ante, cons)
`define CSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/csp_pkg.sv
package csp_pkg;

	localparam int NAME_SLOTS    = 11;
	localparam int NAME_COUNT_DEF = 11;
	localparam int CHAR_W        = 8;
	localparam int COLOR_W       = 8;
	localparam int HEX_DIGITS    = 6;
	localparam logic [3:0] COUNT_SAT = 4'd8;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam logic FUNC_CHAR = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	// names right-justified, first letter in the highest used byte
	localparam logic [63:0] NAME_TEXT [NAME_SLOTS] = '{
		64'("black"), 64'("white"), 64'("red"), 64'("green"), 64'("blue"),
		64'("cyan"), 64'("magenta"), 64'("yellow"), 64'("orange"),
		64'("gray"), 64'("grey")
	};

	localparam logic [3:0] NAME_LEN [NAME_SLOTS] = '{
		4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd4, 4'd7, 4'd6, 4'd6, 4'd4, 4'd4
	};

	localparam logic [23:0] NAME_RGB [NAME_SLOTS] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
		24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'hFF8000,
		24'h808080, 24'h808080
	};

endpackage

>>> hdl/csp_if.sv
interface csp_req_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [csp_pkg::CHAR_W-1:0]    ch;

	modport source (output valid, output func, output ch, input ready);
	modport sink (input valid, input func, input ch, output ready);
endinterface

interface csp_res_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [csp_pkg::COLOR_W-1:0]   red;
	logic [csp_pkg::COLOR_W-1:0]   green;
	logic [csp_pkg::COLOR_W-1:0]   blue;

	modport source (output valid, output ok, output red, output green, output blue,
		input ready);
	modport sink (input valid, input ok, input red, input green, input blue,
		output ready);
endinterface

>>> hdl/color_string_parser_core.sv
// Color string parser. Characters arrive one per request on char_in (func 0), and an end
// request (func 1) closes the string and yields one color on color_out: leading blanks and
// one '#' are skipped, a body of 6 or 3 hex digits (trailing blanks trimmed) gives RRGGBB or
// RGB scaled by 17, otherwise a case-insensitive exact match against the built-in color names
// is tried; failure gives ok 0 and black. Each request passes an input register and one stage
// of parse logic. With color_out ready, one request is taken every cycle, a color is valid
// once its end request has passed the input and result registers, and the parser is ready for
// the next string right away. An end request waits in the input register while the previous
// color is still held unaccepted on color_out, and char_in is not ready during that wait.
`include "color_string_parser_core_defines.svh"

module color_string_parser_core #(
	parameter int NAME_COUNT = csp_pkg::NAME_COUNT_DEF
) (
	input logic     clk,
	input logic     arst_n,
	csp_req_if.sink char_in,
	csp_res_if.source color_out
);
	import csp_pkg::*;

	logic             valid_s1;
	logic             func_s1;
	logic [7:0]       ch_s1;

	logic             in_body_q;
	logic [3:0]       char_count_q;
	logic [3:0]       trimmed_q;
	logic [3:0]       nib_q [HEX_DIGITS];
	logic [5:0]       hexv_q;
	logic [NAME_COUNT-1:0] hits_q;

	logic             out_valid_q;
	logic             ok_q;
	logic [7:0]       red_q, green_q, blue_q;

	logic             advance;
	logic             fire_s1;
	logic             res_load;
	logic             blank;
	logic             is_hex;
	logic [3:0]       nib_v;
	logic [7:0]       low;
	logic             body_char;
	logic [3:0]       cc_next;
	logic [NAME_COUNT-1:0] hits_next;
	logic [2:0]       sel;

	logic             res_ok;
	logic [23:0]      res_rgb;
	logic             hex6, hex3;

	assign advance   = (func_s1 == FUNC_CHAR) || !out_valid_q || color_out.ready;
	assign fire_s1   = valid_s1 && advance;
	assign res_load  = fire_s1 && (func_s1 == FUNC_END);
	assign char_in.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.valid && char_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			func_s1 <= char_in.func;
			ch_s1   <= char_in.ch;
		end
	end

	// character decode
	always_comb begin
		blank = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB);
		is_hex = 1'b1;
		nib_v  = 4'd0;
		if (ch_s1 >= "0" && ch_s1 <= "9") begin
			nib_v = 4'(ch_s1 - 8'("0"));
		end else if (ch_s1 >= "a" && ch_s1 <= "f") begin
			nib_v = 4'(ch_s1 - 8'("a") + 8'd10);
		end else if (ch_s1 >= "A" && ch_s1 <= "F") begin
			nib_v = 4'(ch_s1 - 8'("A") + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
		low = (ch_s1 >= "A" && ch_s1 <= "Z") ? (ch_s1 + 8'h20) : ch_s1;
		body_char = in_body_q || (!blank && ch_s1 != CH_HASH);
		cc_next = (char_count_q < COUNT_SAT) ? (char_count_q + 4'd1) : char_count_q;
		for (int k = 0; k < NAME_COUNT; k++) begin
			sel = 3'(NAME_LEN[k] - 4'd1 - char_count_q);
			hits_next[k] = hits_q[k] && (char_count_q < NAME_LEN[k])
				&& (NAME_TEXT[k][{sel, 3'b000} +: 8] == low);
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q    <= 1'b0;
			char_count_q <= 4'd0;
			trimmed_q    <= 4'd0;
			hexv_q       <= 6'd0;
			hits_q       <= '1;
		end else if (fire_s1) begin
			if (func_s1 == FUNC_END) begin
				in_body_q    <= 1'b0;
				char_count_q <= 4'd0;
				trimmed_q    <= 4'd0;
				hexv_q       <= 6'd0;
				hits_q       <= '1;
			end else if (!in_body_q && blank) begin
				in_body_q <= 1'b0;
			end else if (!body_char) begin
				in_body_q <= 1'b1;
			end else begin
				in_body_q    <= 1'b1;
				char_count_q <= cc_next;
				hits_q       <= hits_next;
				if (!blank) begin
					trimmed_q <= cc_next;
				end
				if (char_count_q < 4'(HEX_DIGITS) && is_hex) begin
					hexv_q[char_count_q[2:0]] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && func_s1 == FUNC_CHAR && body_char && is_hex
			&& char_count_q < 4'(HEX_DIGITS)) begin
			nib_q[char_count_q[2:0]] <= nib_v;
		end
	end

	// result select
	always_comb begin
		hex6 = (trimmed_q == 4'd6) && (&hexv_q);
		hex3 = (trimmed_q == 4'd3) && (&hexv_q[2:0]);
		res_ok  = 1'b0;
		res_rgb = 24'd0;
		if (hex6) begin
			res_ok  = 1'b1;
			res_rgb = {nib_q[0], nib_q[1], nib_q[2], nib_q[3], nib_q[4], nib_q[5]};
		end else if (hex3) begin
			res_ok  = 1'b1;
			res_rgb = {nib_q[0], nib_q[0], nib_q[1], nib_q[1], nib_q[2], nib_q[2]};
		end else begin
			for (int k = NAME_COUNT - 1; k >= 0; k--) begin
				if (hits_q[k] && char_count_q == NAME_LEN[k]) begin
					res_ok  = 1'b1;
					res_rgb = NAME_RGB[k];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (color_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			ok_q    <= res_ok;
			red_q   <= res_rgb[23:16];
			green_q <= res_rgb[15:8];
			blue_q  <= res_rgb[7:0];
		end
	end

	assign color_out.valid = out_valid_q;
	assign color_out.ok    = ok_q;
	assign color_out.red   = red_q;
	assign color_out.green = green_q;
	assign color_out.blue  = blue_q;

	`CSP_ASSERT_SAME(a_count_sat, 1'b1, char_count_q <= COUNT_SAT && trimmed_q <= char_count_q)
	`CSP_ASSERT_NEXT(a_end_clears, res_load,
		char_count_q == 4'd0 && !in_body_q && hexv_q == 6'd0 && (&hits_q))
	`CSP_ASSERT_NEXT(a_end_held, valid_s1 && func_s1 == FUNC_END && out_valid_q
		&& !color_out.ready, valid_s1 && func_s1 == FUNC_END)
	`CSP_ASSERT_SAME(a_fail_black, out_valid_q && !ok_q,
		red_q == 8'd0 && green_q == 8'd0 && blue_q == 8'd0)

endmodule
